### src/mvse_pkg.sv
// ----------------------------------------------------------------------------
// mvse_pkg
// Shared constants, codes and types of the memory value scan engine.
// ----------------------------------------------------------------------------
package mvse_pkg;

   localparam int MAX_RESULTS = 64;
   localparam int TBL_AW      = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int ADDR_W      = 32;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int IDX_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int SIZE_W      = 2;

   localparam logic [ADDR_W-1:0] START_RST = 32'h4880_0000;
   localparam logic [ADDR_W-1:0] END_RST   = 32'h49FF_FFFF;
   localparam logic [ADDR_W-1:0] LOW_RST   = 32'h4880_0000;
   localparam logic [ADDR_W-1:0] HIGH_RST  = 32'h49FF_FFFF;

   localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00FF;
   localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;
   localparam logic [DATA_W-1:0] WORD_MASK = 32'hFFFF_FFFF;
   localparam logic [ADDR_W-1:0] ADDR_KEEP = ~32'h4000_0000;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

   localparam logic [ADDR_W-1:0] STRIDE_BYTE = 32'd1;
   localparam logic [ADDR_W-1:0] STRIDE_HALF = 32'd2;
   localparam logic [ADDR_W-1:0] STRIDE_WORD = 32'd4;

   typedef enum logic [1:0] {
      ST_STOPPED   = 2'd0,
      ST_IDLE      = 2'd1,
      ST_SEARCHING = 2'd2,
      ST_FINISHED  = 2'd3
   } state_type;

   typedef enum logic [OP_W-1:0] {
      OP_ENABLE = 3'd0,
      OP_STOP   = 3'd1,
      OP_BEGIN  = 3'd2,
      OP_CANCEL = 3'd3,
      OP_STEP   = 3'd4,
      OP_READ   = 3'd5
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEARCH_VALUE = 3'd0,
      CSR_SEARCH_MODE  = 3'd1,
      CSR_SEARCH_SIZE  = 3'd2,
      CSR_START_ADDR   = 3'd3,
      CSR_END_ADDR     = 3'd4,
      CSR_LOW_BOUND    = 3'd5,
      CSR_HIGH_BOUND   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] search_value;
      logic              search_mode;
      logic [SIZE_W-1:0] search_size;
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic [ADDR_W-1:0] low_bound;
      logic [ADDR_W-1:0] high_bound;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      entry_type         entry;
   } tbl_wr_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] mem_data;
      logic [IDX_W-1:0]  result_index;
   } item_type;

   typedef struct packed {
      logic              status;
      logic [1:0]        run_state;
      logic [ADDR_W-1:0] scan_address;
      logic              hit;
      logic [ADDR_W-1:0] hit_address;
      logic [DATA_W-1:0] hit_value;
      logic [CNT_W-1:0]  match_count;
      logic              read_valid;
      logic [ADDR_W-1:0] read_address;
      logic [DATA_W-1:0] read_value;
   } rsp_type;

endpackage

### src/mvse_if.sv
// ----------------------------------------------------------------------------
// mvse_if
// Valid/ready channels of the scan engine: command items in, results out.
// ----------------------------------------------------------------------------
interface mvse_req_if;
   logic                         valid;
   logic                         ready;
   logic [mvse_pkg::OP_W-1:0]    opcode;
   logic [mvse_pkg::DATA_W-1:0]  mem_data;
   logic [mvse_pkg::IDX_W-1:0]   result_index;

   modport source (output valid, output opcode, output mem_data, output result_index,
                   input ready);
   modport sink   (input valid, input opcode, input mem_data, input result_index,
                   output ready);
endinterface

interface mvse_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [1:0]                   run_state;
   logic [mvse_pkg::ADDR_W-1:0]  scan_address;
   logic                         hit;
   logic [mvse_pkg::ADDR_W-1:0]  hit_address;
   logic [mvse_pkg::DATA_W-1:0]  hit_value;
   logic [mvse_pkg::CNT_W-1:0]   match_count;
   logic                         read_valid;
   logic [mvse_pkg::ADDR_W-1:0]  read_address;
   logic [mvse_pkg::DATA_W-1:0]  read_value;

   modport source (output valid, output status, output run_state, output scan_address,
                   output hit, output hit_address, output hit_value, output match_count,
                   output read_valid, output read_address, output read_value,
                   input ready);
   modport sink   (input valid, input status, input run_state, input scan_address,
                   input hit, input hit_address, input hit_value, input match_count,
                   input read_valid, input read_address, input read_value,
                   output ready);
endinterface

### src/mvse_table.sv
// ----------------------------------------------------------------------------
// mvse_table
// Match table: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module mvse_table (
   input  logic                          clock,
   input  mvse_pkg::tbl_wr_type          wr,
   input  logic                          rd_en,
   input  logic [mvse_pkg::TBL_AW-1:0]   rd_addr,
   output mvse_pkg::entry_type           rd_data
);

   mvse_pkg::entry_type entry_mem [mvse_pkg::MAX_RESULTS];
   mvse_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= wr.entry;
      end
      if (rd_en) begin
         // entry written by the item ahead of this one
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.entry;
         end else begin
            rd_data_ff <= entry_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mvse_step.sv
// ----------------------------------------------------------------------------
// mvse_step
// Scan state registers and the per-item command and compare logic.
// ----------------------------------------------------------------------------
module mvse_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 commit,
   input  mvse_pkg::item_type   item,
   input  mvse_pkg::entry_type  rd_entry,
   input  mvse_pkg::cfg_type    cfg,
   output mvse_pkg::rsp_type    res,
   output mvse_pkg::tbl_wr_type tbl_wr
);

   mvse_pkg::state_type                state_ff, state_in;
   logic [mvse_pkg::ADDR_W-1:0]        pos_ff, pos_in;
   logic [mvse_pkg::CNT_W-1:0]         count_ff, count_in;

   logic                               start_ok;
   logic                               clamp;
   logic                               past_end;
   logic [mvse_pkg::ADDR_W-1:0]        pos1;
   logic [mvse_pkg::DATA_W-1:0]        dmask;
   logic [mvse_pkg::ADDR_W-1:0]        stride;
   logic [mvse_pkg::DATA_W-1:0]        data_m;
   logic                               match;
   logic [mvse_pkg::ADDR_W-1:0]        next_old;
   logic [mvse_pkg::ADDR_W-1:0]        next_start;
   logic [mvse_pkg::ADDR_W-1:0]        next_sel;
   logic                               next_ok;
   logic                               full;
   logic                               rvalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvse_pkg::ST_STOPPED;
         pos_ff   <= mvse_pkg::LOW_RST;
         count_ff <= '0;
      end else if (commit) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   // compare width and stride
   always_comb begin
      if (cfg.search_mode) begin
         dmask  = mvse_pkg::HALF_MASK;
         stride = mvse_pkg::STRIDE_WORD;
         data_m = item.mem_data;
      end else begin
         case (cfg.search_size)
            mvse_pkg::SIZE_BYTE: begin
               dmask  = mvse_pkg::BYTE_MASK;
               stride = mvse_pkg::STRIDE_BYTE;
            end
            mvse_pkg::SIZE_HALF: begin
               dmask  = mvse_pkg::HALF_MASK;
               stride = mvse_pkg::STRIDE_HALF;
            end
            default: begin
               dmask  = mvse_pkg::WORD_MASK;
               stride = mvse_pkg::STRIDE_WORD;
            end
         endcase
         data_m = item.mem_data & dmask;
      end
   end

   always_comb begin
      start_ok   = (cfg.start_addr >= cfg.low_bound) && (cfg.start_addr <= cfg.high_bound);
      clamp      = (pos_ff < cfg.start_addr) && start_ok;
      pos1       = clamp ? cfg.start_addr : pos_ff;
      past_end   = pos_ff > cfg.end_addr;
      match      = (item.mem_data & dmask) == (cfg.search_value & dmask);
      // both candidate next addresses in parallel, picked after the add
      next_old   = pos_ff + stride;
      next_start = cfg.start_addr + stride;
      next_sel   = clamp ? next_start : next_old;
      next_ok    = (next_sel >= cfg.low_bound) && (next_sel <= cfg.high_bound);
      full       = count_ff >= mvse_pkg::CNT_W'(mvse_pkg::MAX_RESULTS);
      rvalid     = 1'b0;

      state_in = state_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      res      = '0;
      tbl_wr   = '0;
      tbl_wr.addr        = count_ff[mvse_pkg::TBL_AW-1:0];
      tbl_wr.entry.addr  = pos1 & mvse_pkg::ADDR_KEEP;
      tbl_wr.entry.value = data_m;

      case (mvse_pkg::opcode_type'(item.opcode))
         mvse_pkg::OP_ENABLE: begin
            state_in = mvse_pkg::ST_IDLE;
         end
         mvse_pkg::OP_STOP: begin
            state_in = mvse_pkg::ST_STOPPED;
         end
         mvse_pkg::OP_BEGIN: begin
            if (state_ff != mvse_pkg::ST_IDLE) begin
               res.status = 1'b1;
            end else begin
               count_in = '0;
               pos_in   = cfg.low_bound;
               state_in = mvse_pkg::ST_SEARCHING;
            end
         end
         mvse_pkg::OP_CANCEL: begin
            if (state_ff != mvse_pkg::ST_SEARCHING) begin
               res.status = 1'b1;
            end else begin
               state_in = mvse_pkg::ST_FINISHED;
            end
         end
         mvse_pkg::OP_STEP: begin
            if (state_ff == mvse_pkg::ST_SEARCHING) begin
               if (past_end) begin
                  pos_in   = pos1;
                  state_in = mvse_pkg::ST_FINISHED;
               end else begin
                  if (match) begin
                     if (full) begin
                        state_in = mvse_pkg::ST_FINISHED;
                     end else begin
                        tbl_wr.en       = commit;
                        res.hit         = 1'b1;
                        res.hit_address = tbl_wr.entry.addr;
                        res.hit_value   = data_m;
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  if (next_ok) begin
                     pos_in = next_sel;
                  end else begin
                     pos_in   = pos1;
                     state_in = mvse_pkg::ST_FINISHED;
                  end
               end
            end
         end
         mvse_pkg::OP_READ: begin
            rvalid = mvse_pkg::CNT_W'(item.result_index) < count_ff;
         end
         default: begin
            res.status = 1'b1;
         end
      endcase

      res.run_state    = state_in;
      res.scan_address = pos_in;
      res.match_count  = count_in;
      res.read_valid   = rvalid;
      res.read_address = rvalid ? rd_entry.addr : '0;
      res.read_value   = rvalid ? rd_entry.value : '0;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mvse_pkg::CNT_W'(mvse_pkg::MAX_RESULTS))
      else $error("match count beyond table depth");

   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      commit && res.hit |=> count_ff == mvse_pkg::CNT_W'($past(count_ff) + 1'b1))
      else $error("stored match did not bump the count");

   a_hit_searching: assert property (@(posedge clock) disable iff (reset)
      commit && res.hit |-> state_ff == mvse_pkg::ST_SEARCHING)
      else $error("match stored outside a search");

   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      commit && res.status |=> state_ff == $past(state_ff) && pos_ff == $past(pos_ff)
                               && count_ff == $past(count_ff))
      else $error("refused command changed the scan state");

endmodule

### src/memory_value_scan_engine_top.sv
// ----------------------------------------------------------------------------
// memory_value_scan_engine_top
// Memory value scan engine: walks an address range, compares each data word
// brought in by a step command and records matches in a 64-entry table.
//
// Usage: command items (opcode, mem_data, result_index) arrive on req_ch,
// one result per item leaves on rsp_ch; both are valid/ready, a transfer
// happens when valid and ready are high at a clock edge. scan_address in a
// result is the next scan position; a step clamps it up to a valid start_addr.
// An item passes from the req_ch transfer through one input register that also
// holds the registered table read, then the result register, to rsp_ch. One
// item per cycle is sustained while rsp_ch is ready; each item is handled in
// one pass of the compare and address logic, and the table has one write and
// one read port per cycle. The user must write the registers over csr_we/
// csr_index/csr_wdata only while no item is in flight; the block itself does not
// enforce it. Synchronous reset returns to the stopped state with the default
// range; the match table is not cleared (only entries below the match count
// are ever read back). When rsp_ch stalls, the result register holds and
// the input register takes one more item before req_ch.ready drops.
// ----------------------------------------------------------------------------
module memory_value_scan_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   mvse_req_if.sink                           req_ch,
   mvse_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [mvse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvse_pkg::DATA_W-1:0]        csr_wdata
);

   mvse_pkg::cfg_type    cfg_ff;
   logic                 s1_valid_ff;
   mvse_pkg::item_type   s1_item_ff;
   logic                 rsp_valid_ff;
   mvse_pkg::rsp_type    rsp_ff;

   logic                 advance;
   logic                 accept;
   mvse_pkg::entry_type  rd_entry;
   mvse_pkg::rsp_type    step_res;
   mvse_pkg::tbl_wr_type tbl_wr;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_value <= '0;
         cfg_ff.search_mode  <= 1'b0;
         cfg_ff.search_size  <= mvse_pkg::SIZE_WORD;
         cfg_ff.start_addr   <= mvse_pkg::START_RST;
         cfg_ff.end_addr     <= mvse_pkg::END_RST;
         cfg_ff.low_bound    <= mvse_pkg::LOW_RST;
         cfg_ff.high_bound   <= mvse_pkg::HIGH_RST;
      end else if (csr_we) begin
         case (mvse_pkg::csr_index_type'(csr_index))
            mvse_pkg::CSR_SEARCH_VALUE: cfg_ff.search_value <= csr_wdata;
            mvse_pkg::CSR_SEARCH_MODE:  cfg_ff.search_mode  <= csr_wdata[0];
            mvse_pkg::CSR_SEARCH_SIZE:  cfg_ff.search_size  <= csr_wdata[mvse_pkg::SIZE_W-1:0];
            mvse_pkg::CSR_START_ADDR:   cfg_ff.start_addr   <= csr_wdata;
            mvse_pkg::CSR_END_ADDR:     cfg_ff.end_addr     <= csr_wdata;
            mvse_pkg::CSR_LOW_BOUND:    cfg_ff.low_bound    <= csr_wdata;
            mvse_pkg::CSR_HIGH_BOUND:   cfg_ff.high_bound   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.opcode       <= req_ch.opcode;
         s1_item_ff.mem_data     <= req_ch.mem_data;
         s1_item_ff.result_index <= req_ch.result_index;
      end
   end

   mvse_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_en   (accept),
      .rd_addr (req_ch.result_index[mvse_pkg::TBL_AW-1:0]),
      .rd_data (rd_entry)
   );

   mvse_step u_step (
      .clock    (clock),
      .reset    (reset),
      .commit   (advance),
      .item     (s1_item_ff),
      .rd_entry (rd_entry),
      .cfg      (cfg_ff),
      .res      (step_res),
      .tbl_wr   (tbl_wr)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.run_state    = rsp_ff.run_state;
   assign rsp_ch.scan_address = rsp_ff.scan_address;
   assign rsp_ch.hit          = rsp_ff.hit;
   assign rsp_ch.hit_address  = rsp_ff.hit_address;
   assign rsp_ch.hit_value    = rsp_ff.hit_value;
   assign rsp_ch.match_count  = rsp_ff.match_count;
   assign rsp_ch.read_valid   = rsp_ff.read_valid;
   assign rsp_ch.read_address = rsp_ff.read_address;
   assign rsp_ch.read_value   = rsp_ff.read_value;

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("waiting item lost from the input register");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("committed item produced no result");

endmodule
